@@ sv/bfsr_pkg.sv @@
// Package for the bounded FIFO with search and remove.
// Holds the item types, mode and status codes and default sizes.
// No dependencies.
package bfsr_pkg;

  // Default number of entry cells.
  localparam int DEPTH_DEFAULT = 64;

  // Field widths of the items.
  localparam int MODE_W  = 2;
  localparam int DATA_W  = 31;
  localparam int TIME_W  = 48;
  localparam int INDEX_W = 7;
  localparam int STAT_W  = 2;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;
  localparam int CAP_W   = 7;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;
  localparam logic [CAP_W-1:0]   CAPACITY_RESET = 7'd64;

  // Operation codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ    = 2'd0,
    MODE_DEQ    = 2'd1,
    MODE_FIND   = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_t;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

  // Request item.
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [DATA_W-1:0]  data_in;
    logic [TIME_W-1:0]  stamp;
    logic [INDEX_W-1:0] index;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [DATA_W-1:0]  data_out;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  head_time;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic apply;
  } dp_cmd_t;

endpackage

@@ sv/bounded_fifo_with_search_and_remove.sv @@
// Top level of the bounded FIFO with search and remove: capacity register,
// controller and datapath. Depends on bfsr_pkg, bfsr_ctrl and bfsr_dp.
//
//  channel   signals                              direction
//  req       req_valid, req_stall, req            in_item_t into the block
//  rsp       rsp_valid, rsp_stall, rsp            out_item_t out of the block
//  config    psel, penable, pwrite, paddr, ...    capacity register, APB style
//
// Each item is first taken in, with every cell compared with its data word,
// and then applied to the cell chain while the result is loaded.
// A new item is taken while a finished result still waits in its register;
// a held result stalls only the apply cycle of the next item.
// Reset (rst, synchronous) empties the queue and sets capacity to 64.
module bounded_fifo_with_search_and_remove
  import bfsr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  in_item_t           req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output out_item_t          rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [CAP_W-1:0] capacity;
  dp_cmd_t          cmd;
  logic             reg_hit;

  // Capacity register.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_CAPACITY);
  assign prdata  = reg_hit ? PDATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  bfsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  bfsr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req      (req),
    .capacity (capacity),
    .rsp      (rsp)
  );

endmodule

@@ sv/bfsr_ctrl.sv @@
// Controller of the bounded FIFO: takes an item, then applies it once the
// result register is free. Depends on bfsr_pkg.
module bfsr_ctrl
  import bfsr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  output logic    rsp_valid,
  input  logic    rsp_stall,
  output dp_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  // Requests are taken only while no item is held.
  assign req_stall   = (state == S_EXEC);
  assign cmd.capture = req_valid && (state == S_IDLE);
  assign cmd.apply   = (state == S_EXEC) && (!rsp_valid || !rsp_stall);

  // State and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.capture) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd.apply) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cmd.apply) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/bfsr_dp.sv @@
// Datapath of the bounded FIFO: a chain of entry cells, the match vector,
// the entry count and the result register. Depends on bfsr_pkg.
module bfsr_dp
  import bfsr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  dp_cmd_t          cmd,
  input  in_item_t         req,
  input  logic [CAP_W-1:0] capacity,
  output out_item_t        rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [TIME_W-1:0] cell_time [DEPTH];
  logic [DATA_W-1:0] shift_data [DEPTH];
  logic [TIME_W-1:0] shift_time [DEPTH];
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  in_item_t          item;
  logic [DEPTH-1:0]  match_vec;
  logic [DATA_W-1:0] taken_data;
  logic [DATA_W-1:0] taken_data_next;
  logic [CMP_W-1:0]  sel_pos;

  logic [CMP_W-1:0]  cnt_x;
  logic [CMP_W-1:0]  idx_x;
  logic [CMP_W-1:0]  take_pos;
  logic              full;
  logic              do_enq;
  logic              do_take;
  logic              found;
  logic [IDX_W-1:0]  first_pos;
  logic [TIME_W-1:0] head_next;
  out_item_t         res_next;
  mode_t             op;

  // Entry selected for removal, looked up while the item is taken.
  assign sel_pos = (mode_t'(req.mode) == MODE_DEQ) ? '0 : CMP_W'(req.index);

  always_comb begin
    taken_data_next = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CMP_W'(i) == sel_pos) begin
        taken_data_next = taken_data_next | cell_data[i];
      end
    end
  end

  // Capture the item, every cell's compare result and the selected data.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item       <= req;
      taken_data <= taken_data_next;
      for (int i = 0; i < DEPTH; i++) begin
        match_vec[i] <= (cell_data[i] == req.data_in) && (CNT_W'(i) < count);
      end
    end
  end

  // Decode of the held operation.
  assign op       = mode_t'(item.mode);
  assign cnt_x    = CMP_W'(count);
  assign idx_x    = CMP_W'(item.index);
  assign full     = (cnt_x >= CMP_W'(capacity)) || (cnt_x >= CMP_W'(DEPTH));
  assign do_enq   = (op == MODE_ENQ) && !full;
  assign take_pos = (op == MODE_DEQ) ? '0 : idx_x;
  assign do_take  = ((op == MODE_DEQ) && (count != '0))
                 || ((op == MODE_REMOVE) && (idx_x < cnt_x));

  // First matching position, lowest index wins.
  always_comb begin
    first_pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        first_pos = IDX_W'(i);
      end
    end
  end
  assign found = |match_vec;

  // Each cell takes its successor when the entry in it or ahead of it is removed.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g < DEPTH - 1) begin : g_mid
      assign shift_data[g] = cell_data[g+1];
      assign shift_time[g] = cell_time[g+1];
    end else begin : g_last
      assign shift_data[g] = cell_data[g];
      assign shift_time[g] = cell_time[g];
    end

    always_ff @(posedge clk) begin
      if (cmd.apply) begin
        if (do_enq && (CMP_W'(g) == cnt_x)) begin
          cell_data[g] <= item.data_in;
          cell_time[g] <= item.stamp;
        end else if (do_take && (CMP_W'(g) >= take_pos)) begin
          cell_data[g] <= shift_data[g];
          cell_time[g] <= shift_time[g];
        end
      end
    end
  end

  // Entry count after the operation.
  always_comb begin
    if (do_enq) begin
      count_next = count + 1'b1;
    end else if (do_take) begin
      count_next = count - 1'b1;
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.apply) begin
      count <= count_next;
    end
  end

  // Head arrival time after the operation.
  always_comb begin
    if (count_next == '0) begin
      head_next = '0;
    end else if (do_enq && (count == '0)) begin
      head_next = item.stamp;
    end else if (do_take && (take_pos == '0)) begin
      head_next = cell_time[1];
    end else begin
      head_next = cell_time[0];
    end
  end

  // Result fields.
  always_comb begin
    res_next           = '0;
    res_next.count     = COUNT_W'(count_next);
    res_next.head_time = head_next;
    res_next.data_out  = do_take ? taken_data : '0;
    case (op)
      MODE_ENQ: begin
        res_next.status = full ? ST_FULL : ST_OK;
      end
      MODE_DEQ: begin
        res_next.status = do_take ? ST_OK : ST_MISS;
      end
      MODE_FIND: begin
        res_next.status   = found ? ST_OK : ST_MISS;
        res_next.position = found ? POS_W'(first_pos) : '0;
      end
      MODE_REMOVE: begin
        res_next.status = do_take ? ST_OK : ST_MISS;
      end
      default: begin
        res_next.status = ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      rsp <= res_next;
    end
  end

endmodule

@@ verif/tb_top.sv @@
// Testbench for the bounded FIFO with search and remove: directed and random items,
// checked field by field against a queue model kept in the testbench.
// Depends on bfsr_pkg and bounded_fifo_with_search_and_remove.
module tb_top
  import bfsr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH = DEPTH_DEFAULT;
  localparam int HOLD_CYCLES = 200;
  localparam int REPORT_MAX = 10;
  localparam logic [DATA_W-1:0] DATA_MAX = '1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  logic               clk = 1'b0;
  logic               rst;
  logic               req_valid;
  logic               req_stall;
  in_item_t           req;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  out_item_t          rsp;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Queue model: entries from head to tail, count and capacity register.
  logic [DATA_W-1:0] model_data [QUEUE_DEPTH];
  logic [TIME_W-1:0] model_time [QUEUE_DEPTH];
  int model_count = 0;
  int model_cap = 64;

  // Results predicted for accepted items, oldest first.
  out_item_t pending_results[$];

  int mismatches = 0;
  int results_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Long receiver hold-offs are ordered by the tests and counted by the receiver.
  int hold_ordered = 0;
  int hold_taken = 0;
  int hold_left = 0;

  bounded_fifo_with_search_and_remove #(.DEPTH(QUEUE_DEPTH)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Count a failure and report the first few of them.
  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("%s", msg);
    end
  endfunction

  // Take out the entry at pos and close the gap behind it.
  function automatic logic [DATA_W-1:0] take_entry(int pos);
    logic [DATA_W-1:0] d;
    int i;
    d = model_data[pos];
    for (i = pos; i + 1 < model_count; i++) begin
      model_data[i] = model_data[i + 1];
      model_time[i] = model_time[i + 1];
    end
    model_count--;
    return d;
  endfunction

  // Apply one item to the queue model and return the result it causes.
  function automatic out_item_t queue_model_apply(in_item_t it);
    out_item_t r;
    int lim;
    int i;
    logic found;
    r = '0;
    r.status = ST_OK;
    lim = (model_cap > QUEUE_DEPTH) ? QUEUE_DEPTH : model_cap;
    case (it.mode)
      MODE_ENQ: begin
        if (model_count >= lim) begin
          r.status = ST_FULL;
        end else begin
          model_data[model_count] = it.data_in;
          model_time[model_count] = it.stamp;
          model_count++;
        end
      end
      MODE_DEQ: begin
        if (model_count == 0) r.status = ST_MISS;
        else r.data_out = take_entry(0);
      end
      MODE_FIND: begin
        // The first match from the head wins.
        found = 1'b0;
        for (i = 0; i < model_count; i++) begin
          if (!found && model_data[i] == it.data_in) begin
            found = 1'b1;
            r.position = i[POS_W-1:0];
          end
        end
        if (!found) r.status = ST_MISS;
      end
      default: begin
        if (int'(it.index) >= model_count) r.status = ST_MISS;
        else r.data_out = take_entry(int'(it.index));
      end
    endcase
    r.count = model_count[COUNT_W-1:0];
    r.head_time = (model_count != 0) ? model_time[0] : '0;
    return r;
  endfunction

  function automatic in_item_t make_item(mode_t m, logic [DATA_W-1:0] d,
                                         logic [TIME_W-1:0] t, logic [INDEX_W-1:0] idx);
    in_item_t it;
    it.mode = m;
    it.data_in = d;
    it.stamp = t;
    it.index = idx;
    return it;
  endfunction

  // Timestamps: mostly random, sometimes the extremes.
  function automatic logic [TIME_W-1:0] random_stamp();
    logic [63:0] t;
    t = {$urandom(), $urandom()};
    case ($urandom_range(9))
      0: return '0;
      1: return TIME_MAX;
      default: return t[TIME_W-1:0];
    endcase
  endfunction

  // Data words: copies of held entries and a small pool give matches and duplicates.
  function automatic logic [DATA_W-1:0] random_data();
    int r;
    logic [31:0] w;
    r = $urandom_range(99);
    w = $urandom();
    if (r < 30 && model_count > 0) return model_data[$urandom_range(model_count - 1)];
    if (r < 50) return DATA_W'(w[2:0]);
    if (r < 55) return '0;
    if (r < 60) return DATA_MAX;
    return w[DATA_W-1:0];
  endfunction

  // Offer one item, hold it until accepted, then record its predicted result.
  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req <= it;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_results.push_back(queue_model_apply(it));
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic wait_results_drained();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the capacity register while idle, then read it back.
  task automatic write_capacity(int value);
    logic [PDATA_W-1:0] wd;
    wait_results_drained();
    wd = $urandom();
    wd[CAP_W-1:0] = value[CAP_W-1:0];
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_CAPACITY, 2'b00};
    pwdata <= wd;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    model_cap = int'(value[CAP_W-1:0]);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[CAP_W-1:0] !== value[CAP_W-1:0]) begin
      note_failure($sformatf("capacity read back %0d, expected %0d",
                             prdata[CAP_W-1:0], value[CAP_W-1:0]));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Compare one accepted result with the oldest prediction.
  task automatic check_result(out_item_t got);
    out_item_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      note_failure($sformatf("result %0d arrived with nothing expected", results_seen));
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status || got.data_out !== want.data_out ||
        got.position !== want.position || got.count !== want.count ||
        got.head_time !== want.head_time) begin
      note_failure($sformatf({"result %0d: expected status %0d data %h pos %0d count %0d",
                              " head %h, got status %0d data %h pos %0d count %0d head %h"},
                             results_seen, want.status, want.data_out, want.position,
                             want.count, want.head_time, got.status, got.data_out,
                             got.position, got.count, got.head_time));
    end
  endtask

  // Receiver: check accepted results and drive the stall, random or held off.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      check_result(rsp);
    end
    if (hold_taken != hold_ordered) begin
      hold_taken = hold_ordered;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Dequeue, find and remove on an empty queue, with the widest index.
  task automatic test_empty_queue();
    send_item(make_item(MODE_DEQ, '0, '0, '0));
    send_item(make_item(MODE_FIND, DATA_MAX, TIME_MAX, '0));
    send_item(make_item(MODE_REMOVE, '0, '0, '0));
    send_item(make_item(MODE_REMOVE, DATA_MAX, TIME_MAX, '1));
  endtask

  // Enqueue the extreme data and time values and a duplicated data word.
  task automatic test_enqueue_extremes();
    send_item(make_item(MODE_ENQ, '0, '0, '0));
    send_item(make_item(MODE_ENQ, DATA_MAX, TIME_MAX, '1));
    send_item(make_item(MODE_ENQ, 31'd5, 48'h123, 7'd3));
    send_item(make_item(MODE_ENQ, 31'd5, 48'h456, 7'd9));
  endtask

  // Hits at the head, in the middle, the first of two duplicates, and a miss.
  task automatic test_find_first_match();
    send_item(make_item(MODE_FIND, DATA_MAX, random_stamp(), 7'd1));
    send_item(make_item(MODE_FIND, '0, random_stamp(), 7'd0));
    send_item(make_item(MODE_FIND, 31'd5, random_stamp(), 7'd2));
    send_item(make_item(MODE_FIND, 31'd6, random_stamp(), 7'd0));
  endtask

  // Index equal to count is refused; middle and tail removal keep the order.
  task automatic test_remove_at_index();
    send_item(make_item(MODE_REMOVE, '0, '0, 7'd4));
    send_item(make_item(MODE_REMOVE, '0, '0, 7'd2));
    send_item(make_item(MODE_REMOVE, '0, '0, 7'd2));
    send_item(make_item(MODE_DEQ, '0, '0, '0));
    send_item(make_item(MODE_DEQ, '0, '0, '0));
  endtask

  // Capacity one, capacity zero, and capacity lowered below the count.
  task automatic test_capacity_limits();
    write_capacity(1);
    send_item(make_item(MODE_ENQ, 31'd9, 48'h10, '0));
    send_item(make_item(MODE_ENQ, 31'd10, 48'h20, '0));
    write_capacity(0);
    send_item(make_item(MODE_ENQ, 31'd11, 48'h30, '0));
    send_item(make_item(MODE_DEQ, '0, '0, '0));
    write_capacity(64);
    send_item(make_item(MODE_ENQ, 31'd1, 48'h1, '0));
    send_item(make_item(MODE_ENQ, 31'd2, 48'h2, '0));
    send_item(make_item(MODE_ENQ, 31'd3, 48'h3, '0));
    write_capacity(2);
    send_item(make_item(MODE_ENQ, 31'd4, 48'h4, '0));
    send_item(make_item(MODE_DEQ, '0, '0, '0));
    send_item(make_item(MODE_DEQ, '0, '0, '0));
    send_item(make_item(MODE_ENQ, 31'd5, 48'h5, '0));
  endtask

  // Random traffic, mostly well-formed: most removes aim at held entries, some finds at held data.
  task automatic run_traffic(int n_items, int enq_pct);
    in_item_t it;
    int k;
    int r;
    for (k = 0; k < n_items; k++) begin
      r = $urandom_range(99);
      if (r < enq_pct) begin
        it.mode = MODE_ENQ;
      end else begin
        case ((r - enq_pct) % 3)
          0: it.mode = MODE_DEQ;
          1: it.mode = MODE_FIND;
          default: it.mode = MODE_REMOVE;
        endcase
      end
      it.data_in = random_data();
      it.stamp = random_stamp();
      if (it.mode == MODE_REMOVE && model_count > 0 && $urandom_range(99) < 80) begin
        it.index = INDEX_W'($urandom_range(model_count - 1));
      end else begin
        it.index = INDEX_W'($urandom_range(127));
      end
      send_item(it);
      // Now and then the sender pauses until everything has come back.
      if ($urandom_range(99) < 3) begin
        wait_results_drained();
      end
    end
  endtask

  // The receiver holds off while the sender keeps offering, so the block fills up.
  task automatic test_backpressure();
    int k;
    hold_ordered++;
    for (k = 0; k < 16; k++) begin
      if (k % 4 == 3) send_item(make_item(MODE_FIND, random_data(), random_stamp(), '0));
      else send_item(make_item(MODE_ENQ, random_data(), random_stamp(), '0));
    end
    wait_results_drained();
  endtask

  initial begin
    req_valid <= 1'b0;
    req <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rst <= 1'b1;
    model_count = 0;
    model_cap = int'(CAPACITY_RESET);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    set_idling(28, 56);
    test_empty_queue();
    test_enqueue_extremes();
    test_find_first_match();
    test_remove_at_index();
    test_capacity_limits();
    // Capacity above the depth: the depth is the limit, so fill the queue.
    write_capacity(127);
    run_traffic(120, 80);
    write_capacity($urandom_range(1, 8));
    run_traffic(60, 50);

    set_idling(56, 28);
    test_backpressure();
    write_capacity(64);
    run_traffic(100, 55);
    write_capacity(0);
    run_traffic(30, 40);
    write_capacity($urandom_range(1, 64));
    run_traffic(90, 50);

    set_idling(0, 0);
    test_backpressure();
    write_capacity(1);
    run_traffic(50, 50);
    write_capacity($urandom_range(0, 127));
    run_traffic(150, 50);

    wait_results_drained();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: 2 ms is many times the slowest correct run.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ bounded_fifo_with_search_and_remove.f @@
sv/bfsr_pkg.sv
sv/bfsr_ctrl.sv
sv/bfsr_dp.sv
sv/bounded_fifo_with_search_and_remove.sv
verif/tb_top.sv
